### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the decimal text converter.
// Standalone header; expects the including module to name its clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SITOD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SITOD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sitod_pkg.sv
// Package for the decimal text converter: digit chain sizes, cell control, ASCII codes.
// No dependencies.
package sitod_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 20;  // 2**64 - 1 has 20 decimal digits
    localparam int ND_W       = 5;   // holds 0..NUM_DIGITS
    localparam int CNT_W      = 6;   // bit counter and pad counter

    typedef logic [3:0]      digit_t;
    typedef logic [ND_W-1:0] nd_t;

    // Control shared by every cell of the digit chain
    typedef struct packed {
        logic clear;  // zero the digit
        logic conv;   // add-3 correction and shift one bit in
        logic shift;  // take the neighbor's digit (move toward the top)
    } cell_ctrl_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [3:0] CH_DIGIT_HI = 4'h3;

endpackage

### hdl/scaled_integer_to_decimal_text.sv
// Top level of the decimal text converter: sequencer plus a chain of BCD digit cells.
// Depends on sitod_pkg, sitod_cell and assert_macros.svh.
//
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------------------
//  input    | value, scale           | taken at a clock edge with start=1, busy=0
//  result   | out_char, last         | strobe=1 for one cycle per character
//
// Zero value: "0" appears the cycle after the item is taken.
// Scale below -18: "***".
// Otherwise: bit-serial conversion through the digit chain, one bit per cycle, then
// the leading zero digits are dropped (20 minus digit count) and the point placed,
// then one character per cycle.
// Reset clears the sequencer and the output strobe; results cannot be stalled.
`include "assert_macros.svh"

module scaled_integer_to_decimal_text
    import sitod_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [63:0]  value,
    input  logic signed [5:0]   scale,
    output logic                strobe,
    output logic [7:0]          out_char,
    output logic                last
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_STAR  = 8'b0000_0010,
        ST_CONV  = 8'b0000_0100,
        ST_SKIP  = 8'b0000_1000,
        ST_SIGN  = 8'b0001_0000,
        ST_LEAD  = 8'b0010_0000,
        ST_PAD   = 8'b0100_0000,
        ST_DIGIT = 8'b1000_0000
    } state_t;

    localparam logic signed [5:0] SCALE_MIN = -6'sd18;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    nd_t                  nd_reg, nd_next;
    logic [5:0]           scale_reg, scale_next;
    logic                 neg_reg, neg_next;
    logic                 point_reg, point_next;
    logic                 strobe_reg, strobe_next;
    logic [7:0]           char_reg, char_next;
    logic                 last_reg, last_next;

    cell_ctrl_t           ctrl;
    logic                 carry [NUM_DIGITS];
    digit_t               dig   [NUM_DIGITS];
    digit_t               top_digit;

    logic                 scale_pos;
    logic                 lead_case;
    logic [4:0]           pad;
    state_t               after_sign;

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign out_char  = char_reg;
    assign last      = last_reg;
    assign top_digit = dig[NUM_DIGITS-1];

    // digit chain: cell 0 is least significant, bits enter there
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        logic   bin;
        digit_t din;
        if (i == 0)
        begin : g_first
            assign bin = mag_reg[VALUE_W-1];
            assign din = '0;
        end
        else
        begin : g_rest
            assign bin = carry[i-1];
            assign din = dig[i-1];
        end
        sitod_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .bit_in    (bin),
            .digit_in  (din),
            .carry_out (carry[i]),
            .digit     (dig[i])
        );
    end

    // point placement decisions from digit count and scale
    assign scale_pos  = !scale_reg[5] && (scale_reg[4:0] != 5'd0);
    assign lead_case  = scale_pos && ({1'b0, nd_reg} <= scale_reg);
    assign pad        = scale_reg[4:0] - nd_reg;
    assign after_sign = lead_case ? ST_LEAD : ST_DIGIT;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        cnt_next    = cnt_reg;
        nd_next     = nd_reg;
        scale_next  = scale_reg;
        neg_next    = neg_reg;
        point_next  = point_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        ctrl        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    scale_next = scale;
                    neg_next   = value[63];
                    if (value == '0)
                    begin
                        strobe_next = 1'b1;
                        char_next   = CH_ZERO;
                        last_next   = 1'b1;
                    end
                    else if (scale < SCALE_MIN)
                    begin
                        cnt_next   = CNT_W'(2);
                        state_next = ST_STAR;
                    end
                    else
                    begin
                        mag_next   = value[63] ? (~value + 64'd1) : value;
                        ctrl.clear = 1'b1;
                        cnt_next   = CNT_W'(VALUE_W - 1);
                        nd_next    = ND_W'(NUM_DIGITS);
                        state_next = ST_CONV;
                    end
                end
            end
            ST_STAR:
            begin
                strobe_next = 1'b1;
                char_next   = CH_STAR;
                last_next   = (cnt_reg == '0);
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CONV:
            begin
                ctrl.conv = 1'b1;
                mag_next  = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zero digits, counting the ones that remain
                if (top_digit == '0)
                begin
                    ctrl.shift = 1'b1;
                    nd_next    = nd_reg - 1'b1;
                end
                else
                begin
                    point_next = scale_pos && ({1'b0, nd_reg} > scale_reg);
                    state_next = neg_reg ? ST_SIGN : after_sign;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CH_MINUS;
                state_next  = after_sign;
            end
            ST_LEAD:
            begin
                strobe_next = 1'b1;
                char_next   = CH_DOT;
                cnt_next    = {1'b0, pad};
                state_next  = (pad != 5'd0) ? ST_PAD : ST_DIGIT;
            end
            ST_PAD:
            begin
                strobe_next = 1'b1;
                char_next   = CH_ZERO;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                strobe_next = 1'b1;
                if (point_reg && ({1'b0, nd_reg} == scale_reg))
                begin
                    char_next  = CH_DOT;
                    point_next = 1'b0;
                end
                else
                begin
                    char_next  = {CH_DIGIT_HI, top_digit};
                    ctrl.shift = 1'b1;
                    nd_next    = nd_reg - 1'b1;
                    last_next  = (nd_reg == ND_W'(1));
                    if (nd_reg == ND_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            cnt_reg    <= '0;
            nd_reg     <= '0;
            point_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            cnt_reg    <= cnt_next;
            nd_reg     <= nd_next;
            point_reg  <= point_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        scale_reg <= scale_next;
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    `SITOD_ASSERT_IMP(a_more_pending, clk, rst_n, strobe_reg && !last_reg, busy, "char without last while idle")
    `SITOD_ASSERT_IMP(a_skip_nonzero, clk, rst_n, state_reg == ST_SKIP, nd_reg != '0, "digit count ran out while skipping zeros")
    `SITOD_ASSERT_NXT(a_first_char, clk, rst_n, start && !busy, !strobe_reg || last_reg, "unexpected char right after accept")

endmodule

### hdl/sitod_cell.sv
// One BCD digit cell of the double-dabble chain; also shifts digits toward the top.
// Depends on sitod_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sitod_cell
    import sitod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       bit_in,
    input  digit_t     digit_in,
    output logic       carry_out,
    output digit_t     digit
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    // add 3 when the digit is 5 or more, so the shift doubles it in decimal
    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.conv)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    `SITOD_ASSERT_IMP(a_digit_bcd, clk, rst_n, 1'b1, digit_reg <= 4'd9, "cell digit above 9")

endmodule

### sim/tb.sv
// Testbench for scaled_integer_to_decimal_text: directed and random items, self-checking.
// Depends on sitod_pkg and the converter RTL; predicts each character of the text.
`timescale 1ns / 100ps

module tb;
    import sitod_pkg::*;

    // One character of the expected text
    typedef struct {
        logic [7:0] ch;
        logic       lst;
    } text_char_t;

    // Holds the expected characters and checks each one that the block emits
    class decimal_text_board;
        text_char_t exp_text[$];
        int         fails;

        function new();
            fails = 0;
        endfunction

        function int pending();
            return exp_text.size();
        endfunction

        // Work out the text of one accepted item and queue its characters
        function void note_item(input logic [63:0] v, input logic signed [5:0] s);
            logic [7:0] line[$];
            logic [3:0] dig[20];
            logic [63:0] mag;
            int         nd;
            int         sc;
            int         i;
            text_char_t tc;
            sc = s;
            nd = 0;
            if (v == 64'd0) begin
                line.push_back(CH_ZERO);
            end
            else if (sc < -18) begin
                line.push_back(CH_STAR);
                line.push_back(CH_STAR);
                line.push_back(CH_STAR);
            end
            else begin
                mag = v[63] ? (~v + 64'd1) : v;
                while (mag != 64'd0 && nd < 20) begin
                    dig[nd] = 4'(mag % 64'd10);
                    mag     = mag / 64'd10;
                    nd++;
                end
                if (v[63])
                    line.push_back(CH_MINUS);
                if (sc > 0 && nd <= sc) begin
                    // too few digits: point first, then zero padding
                    line.push_back(CH_DOT);
                    for (i = nd; i < sc; i++)
                        line.push_back(CH_ZERO);
                    for (i = nd - 1; i >= 0; i--)
                        line.push_back(CH_ZERO + dig[i]);
                end
                else if (sc > 0) begin
                    for (i = nd - 1; i >= sc; i--)
                        line.push_back(CH_ZERO + dig[i]);
                    line.push_back(CH_DOT);
                    for (i = sc - 1; i >= 0; i--)
                        line.push_back(CH_ZERO + dig[i]);
                end
                else begin
                    for (i = nd - 1; i >= 0; i--)
                        line.push_back(CH_ZERO + dig[i]);
                end
            end
            for (i = 0; i < line.size(); i++) begin
                tc.ch  = line[i];
                tc.lst = (i == line.size() - 1);
                exp_text.push_back(tc);
            end
        endfunction

        // Compare one emitted character with the oldest expectation
        function void check_char(input logic [7:0] ch, input logic lst);
            text_char_t tc;
            if (exp_text.size() == 0) begin
                $error("unexpected character: out_char %h last %b", ch, lst);
                fails++;
                return;
            end
            tc = exp_text.pop_front();
            if (ch !== tc.ch) begin
                $error("out_char mismatch: expected %h, actual %h", tc.ch, ch);
                fails++;
            end
            if (lst !== tc.lst) begin
                $error("last mismatch: expected %b, actual %b", tc.lst, lst);
                fails++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [63:0] value;
    logic signed [5:0]  scale;
    logic               strobe;
    logic [7:0]         out_char;
    logic               last;

    decimal_text_board board;
    bit                no_idle;

    scaled_integer_to_decimal_text u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .value    (value),
        .scale    (scale),
        .strobe   (strobe),
        .out_char (out_char),
        .last     (last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(20_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // Result monitor: a character is taken at every edge with strobe high
    always @(posedge clk)
    begin
        if (rst_n && strobe !== 1'b0)
            board.check_char(out_char, last);
    end

    // Offer one item and hold it until the block takes it, then maybe idle.
    // Called right after a rising edge.
    task automatic send_text_item(input logic [63:0] v, input logic [5:0] s);
        int gap;
        start <= 1'b1;
        value <= v;
        scale <= s;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_item(v, s);
        gap = 0;
        if (!no_idle && $urandom_range(99) < 19)
            gap = $urandom_range(1, 100);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random value: mix of full width, short magnitudes, zero and extremes
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int          kind;
        kind = $urandom_range(99);
        if (kind < 30)
            v = {$urandom, $urandom};
        else if (kind < 65)
            v = {$urandom, $urandom} >> $urandom_range(1, 63);
        else if (kind < 90)
            v = 64'($urandom_range(1, 999999));
        else if (kind < 94)
            v = 64'd0;
        else if (kind < 97)
            v = 64'h7FFF_FFFF_FFFF_FFFF;
        else
            v = 64'h8000_0000_0000_0000;
        // random sign for the shorter magnitudes
        if (kind >= 30 && kind < 90 && $urandom_range(1))
            v = ~v + 64'd1;
        return v;
    endfunction

    // Random scale: mostly the printing range, some full-range codes
    function automatic logic [5:0] pick_scale();
        if ($urandom_range(99) < 75)
            return 6'($urandom_range(0, 49) - 18);
        return 6'($urandom_range(0, 63));
    endfunction

    // Stimulus
    initial
    begin
        int n;
        board   = new();
        no_idle = 1'b0;
        rst_n  <= 1'b0;
        start  <= 1'b0;
        value  <= '0;
        scale  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: zero, extremes, point placement, overflow text
        send_text_item(64'd0, 6'd0);
        send_text_item(64'd0, -6'sd32);
        send_text_item(64'd0, 6'd31);
        send_text_item(64'd1, 6'd0);
        send_text_item(-64'sd1, 6'd0);
        send_text_item(64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
        send_text_item(64'h8000_0000_0000_0000, 6'd0);
        send_text_item(64'h8000_0000_0000_0000, 6'd19);
        send_text_item(64'h8000_0000_0000_0000, 6'd31);
        send_text_item(64'h7FFF_FFFF_FFFF_FFFF, -6'sd18);
        send_text_item(64'd123, -6'sd19);
        send_text_item(-64'sd5, -6'sd32);
        send_text_item(64'd10, -6'sd1);
        send_text_item(64'd12345, 6'd2);
        send_text_item(64'd12345, 6'd5);
        send_text_item(64'd12345, 6'd6);
        send_text_item(-64'sd12345, 6'd3);
        send_text_item(64'd7, 6'd1);
        send_text_item(64'd1, 6'd31);
        send_text_item(-64'sd1, 6'd31);
        send_text_item(64'hAAAA_AAAA_AAAA_AAAA, 6'b101010);
        send_text_item(64'h5555_5555_5555_5555, 6'b010101);
        send_text_item(64'hFFFF_FFFF_FFFF_FFFF, 6'd20);

        // random part, with a stretch of back-to-back items
        for (n = 0; n < 260; n++)
        begin
            no_idle = (n >= 120 && n < 180);
            send_text_item(pick_value(), pick_scale());
        end
        no_idle = 1'b0;
        start <= 1'b0;

        // drain, then let the block settle
        while (board.pending() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        if (board.fails == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
